### src/md5_pkg.sv
package md5_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned COUNT_W  = 61;
  localparam int unsigned ROUNDS   = 64;
  localparam int unsigned ROUND_W  = 6;
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned BLK_IDX_W = 4;
  localparam int unsigned LEN_POS  = 56;
  localparam int unsigned LAST_POS = 63;
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam word_t ROUND_K [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [2*WORD_W-1:0] tmp;
    tmp = {x, x} << s;
    return tmp[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [BLK_IDX_W-1:0] msg_index(input logic [ROUND_W-1:0] rnd);
    logic [BLK_IDX_W-1:0] i;
    logic [BLK_IDX_W-1:0] g;
    i = rnd[BLK_IDX_W-1:0];
    unique case (rnd[ROUND_W-1:BLK_IDX_W])
      2'd0: g = i;
      2'd1: g = BLK_IDX_W'(i * 4'd5 + 4'd1);
      2'd2: g = BLK_IDX_W'(i * 4'd3 + 4'd5);
      default: g = BLK_IDX_W'(i * 4'd7);
    endcase
    return g;
  endfunction

  function automatic word_t round_f(input logic [1:0] phase, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    unique case (phase)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

### src/md5_in_if.sv
interface md5_in_if;
  logic                          valid;
  logic                          ready;
  logic [md5_pkg::BYTE_W-1:0]    data_byte;
  logic                          byte_present;
  logic                          end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

### src/md5_out_if.sv
interface md5_out_if;
  logic                          valid;
  logic                          ready;
  logic [md5_pkg::WORD_W-1:0]    digest_word;
  logic [md5_pkg::IDX_W-1:0]     word_number;
  logic                          last_word;

  modport source (output valid, output digest_word, output word_number,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_number,
                  input last_word, output ready);
endinterface

### src/md5_message_digest_unit.sv
// An ordinary byte is stored while idle; the byte that fills a block starts the
// 64 rounds of the single round unit, then the chaining add.
// End of message: 1 or 2 padded blocks (pad, rounds, chaining add), then the
// digest goes to the free output buffer and out as four words at one per cycle
// while out_ch.ready is high. No byte is taken while a block is in process.
// Reset (synchronous, rst high) loads the initial chaining words and clears the count.
module md5_message_digest_unit (
  input  logic      clk,
  input  logic      rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FEED  = 5'b01000,
    ST_HAND  = 5'b10000
  } state_t;

  state_t                          state;
  md5_pkg::word_t                  chain [4];
  md5_pkg::word_t                  blk [md5_pkg::BLK_WORDS];
  md5_pkg::word_t                  pad_words [md5_pkg::BLK_WORDS];
  md5_pkg::word_t                  dgst [4];
  md5_pkg::word_t                  a, b, c, d;
  md5_pkg::word_t                  t_sum, nb;
  logic [md5_pkg::COUNT_W-1:0]     count;
  logic [md5_pkg::ROUND_W-1:0]     rnd;
  logic [md5_pkg::ROUND_W-1:0]     pos;
  logic [md5_pkg::IDX_W-1:0]       out_idx;
  logic                            finish_pending;
  logic                            last_block;
  logic                            pad_second;
  logic                            out_busy;
  logic                            in_fire;
  logic                            out_fire;
  logic                            hand_go;
  logic                            len_here;

  assign pos      = count[md5_pkg::ROUND_W-1:0];
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign hand_go  = (state == ST_HAND) && !out_busy;
  assign len_here = pad_second || (pos < md5_pkg::ROUND_W'(md5_pkg::LEN_POS));

  assign in_ch.ready        = (state == ST_IDLE);
  assign out_ch.valid       = out_busy;
  assign out_ch.digest_word = dgst[out_idx];
  assign out_ch.word_number = out_idx;
  assign out_ch.last_word   = (out_idx == md5_pkg::IDX_W'(3));

  always_comb begin
    t_sum = a + md5_pkg::round_f(rnd[5:4], b, c, d) + blk[md5_pkg::msg_index(rnd)]
            + md5_pkg::ROUND_K[rnd];
    nb    = b + md5_pkg::rotl(t_sum, md5_pkg::ROT_S[{rnd[5:4], rnd[1:0]}]);
  end

  always_comb begin
    logic [md5_pkg::ROUND_W-1:0] p;
    for (int w = 0; w < md5_pkg::BLK_WORDS; w++) begin
      for (int k = 0; k < 4; k++) begin
        p = md5_pkg::ROUND_W'(w * 4 + k);
        if (pad_second || p > pos) begin
          pad_words[w][8*k +: 8] = '0;
        end else if (p == pos) begin
          pad_words[w][8*k +: 8] = md5_pkg::PAD_BYTE;
        end else begin
          pad_words[w][8*k +: 8] = blk[w][8*k +: 8];
        end
      end
    end
    if (len_here) begin
      pad_words[14] = {count[28:0], 3'b000};
      pad_words[15] = count[60:29];
    end
  end

  // block store and digest buffer
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire && in_ch.byte_present) begin
      blk[pos[5:2]][8*pos[1:0] +: 8] <= in_ch.data_byte;
    end else if (state == ST_PAD) begin
      blk <= pad_words;
    end
    if (hand_go) begin
      dgst <= chain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      chain          <= md5_pkg::IV;
      count          <= '0;
      rnd            <= '0;
      finish_pending <= 1'b0;
      last_block     <= 1'b0;
      pad_second     <= 1'b0;
      out_busy       <= 1'b0;
      out_idx        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.byte_present) begin
              count <= count + 1'b1;
            end
            if (in_ch.byte_present && pos == md5_pkg::ROUND_W'(md5_pkg::LAST_POS)) begin
              {a, b, c, d}   <= {chain[0], chain[1], chain[2], chain[3]};
              rnd            <= '0;
              finish_pending <= in_ch.end_of_message;
              state          <= ST_ROUND;
            end else if (in_ch.end_of_message) begin
              finish_pending <= 1'b1;
              state          <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (len_here) begin
            last_block <= 1'b1;
            pad_second <= 1'b0;
          end else begin
            pad_second <= 1'b1;
          end
          {a, b, c, d} <= {chain[0], chain[1], chain[2], chain[3]};
          rnd          <= '0;
          state        <= ST_ROUND;
        end
        ST_ROUND: begin
          a   <= d;
          b   <= nb;
          c   <= b;
          d   <= c;
          rnd <= rnd + 1'b1;
          if (rnd == md5_pkg::ROUND_W'(md5_pkg::ROUNDS - 1)) begin
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          priority if (last_block) begin
            state <= ST_HAND;
          end else if (finish_pending) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_HAND: begin
          if (!out_busy) begin
            chain          <= md5_pkg::IV;
            count          <= '0;
            finish_pending <= 1'b0;
            last_block     <= 1'b0;
            pad_second     <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (hand_go) begin
        out_busy <= 1'b1;
        out_idx  <= '0;
      end else if (out_fire) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == md5_pkg::IDX_W'(3)) begin
          out_busy <= 1'b0;
        end
      end
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == md5_pkg::ROUND_W'(md5_pkg::ROUNDS - 1)) |=> state == ST_FEED)
    else $error("round sequence did not end in chaining add");

  a_second_pad: assert property (@(posedge clk) disable iff (rst)
    pad_second |-> finish_pending)
    else $error("second pad block without closing message");

  a_last_block: assert property (@(posedge clk) disable iff (rst)
    last_block |-> finish_pending)
    else $error("final block flagged without closing message");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_ch.last_word) |=> !out_busy)
    else $error("digest buffer still busy after last word");

  a_hand: assert property (@(posedge clk) disable iff (rst)
    hand_go |=> (out_busy && count == '0 && state == ST_IDLE))
    else $error("digest hand-off did not reinitialize");

endmodule
